### rtl/ufrc_pkg.sv
`default_nettype none
package ufrc_pkg;

    localparam int NUM_ELEMS = 1024;
    localparam int IDX_W     = $clog2(NUM_ELEMS);
    localparam int RANK_W    = 4;
    localparam int FIELD_W   = 10;
    localparam int S_TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FIELD_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [RANK_W-1:0]  t_rank;
    typedef logic [FIELD_W-1:0] t_field;

    localparam t_rank RANK_MAX = t_rank'((1 << RANK_W) - 1);
    localparam t_idx  IDX_LAST = t_idx'(NUM_ELEMS - 1);

    localparam logic CMD_UNION = 1'b0;
    localparam logic CMD_FIND  = 1'b1;

    typedef struct packed {
        t_rank rank;
        t_idx  parent;
    } t_node;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_node wdata;
        logic  re;
        t_idx  raddr;
    } t_mem_req;

    typedef struct packed {
        t_field root;
        logic   merged;
    } t_result;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK,
        ST_FIX_RD,
        ST_FIX,
        ST_FINISH,
        ST_LINK,
        ST_BUMP,
        ST_OUT
    } t_state;

    function automatic t_idx clamp_idx(input t_field v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide >= 32'(NUM_ELEMS)) begin
            return IDX_LAST;
        end
        return t_idx'(v);
    endfunction

endpackage
`default_nettype wire

### rtl/ufrc_mem.sv
`default_nettype none
module ufrc_mem (
    input  wire logic              i_clk,
    input  wire ufrc_pkg::t_mem_req i_req,
    output ufrc_pkg::t_node        o_rdata
);
    import ufrc_pkg::*;

    t_node r_mem [NUM_ELEMS];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/ufrc_out.sv
`default_nettype none
module ufrc_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_res_valid,
    input  wire ufrc_pkg::t_result           i_res,
    output logic                             o_res_ready,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [ufrc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                             o_m_axis_tuser
);
    import ufrc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_res.root);
    assign o_m_axis_tuser  = r_res.merged;

endmodule
`default_nettype wire

### rtl/ufrc_ctrl.sv
`default_nettype none
module ufrc_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [ufrc_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                        i_s_axis_tuser,
    output ufrc_pkg::t_mem_req               o_mem_req,
    input  wire ufrc_pkg::t_node             i_mem_rdata,
    output logic                             o_res_valid,
    output ufrc_pkg::t_result                o_res,
    input  wire logic                        i_res_ready
);
    import ufrc_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_idx    r_clr;
    logic    r_cmd;
    logic    r_phase;
    t_idx    r_b;
    t_idx    r_start;
    t_idx    r_cur;
    t_idx    r_node;
    t_idx    r_root;
    t_rank   r_rank;
    t_idx    r_ra;
    t_rank   r_rank_a;
    t_result r_res;

    logic  s_accept;
    logic  s_found;
    logic  s_fix_end;
    t_node w;

    assign w         = i_mem_rdata;
    assign s_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign s_found   = (w.parent == r_cur);
    assign s_fix_end = (w.parent == r_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + t_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    r_cmd   <= i_s_axis_tuser;
                    r_phase <= 1'b0;
                    r_start <= clamp_idx(i_s_axis_tdata[FIELD_W-1:0]);
                    r_cur   <= clamp_idx(i_s_axis_tdata[FIELD_W-1:0]);
                    r_b     <= clamp_idx(i_s_axis_tdata[2*FIELD_W-1:FIELD_W]);
                end
            end
            ST_WALK: begin
                if (s_found) begin
                    r_root <= r_cur;
                    r_rank <= w.rank;
                    r_node <= r_start;
                end else begin
                    r_cur <= w.parent;
                end
            end
            ST_FIX: begin
                r_node <= w.parent;
            end
            ST_FINISH: begin
                if (r_cmd == CMD_FIND) begin
                    r_res <= '{root: FIELD_W'(r_root), merged: 1'b0};
                end else if (!r_phase) begin
                    r_ra     <= r_root;
                    r_rank_a <= r_rank;
                    r_start  <= r_b;
                    r_cur    <= r_b;
                    r_phase  <= 1'b1;
                end
            end
            ST_LINK: begin
                if (r_ra == r_root) begin
                    r_res <= '{root: FIELD_W'(r_ra), merged: 1'b0};
                end else if (r_rank_a < r_rank) begin
                    r_res <= '{root: FIELD_W'(r_root), merged: 1'b1};
                end else begin
                    r_res <= '{root: FIELD_W'(r_ra), merged: 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (r_clr == IDX_LAST) n_state = ST_IDLE;
            ST_IDLE:    if (s_accept) n_state = ST_WALK_RD;
            ST_WALK_RD: n_state = ST_WALK;
            ST_WALK:    if (s_found) n_state = ST_FIX_RD;
            ST_FIX_RD:  n_state = (r_node == r_root) ? ST_FINISH : ST_FIX;
            ST_FIX:     if (s_fix_end) n_state = ST_FINISH;
            ST_FINISH: begin
                if (r_cmd == CMD_FIND) begin
                    n_state = ST_OUT;
                end else if (!r_phase) begin
                    n_state = ST_WALK_RD;
                end else begin
                    n_state = ST_LINK;
                end
            end
            ST_LINK: begin
                if (r_ra != r_root && r_rank_a == r_rank) begin
                    n_state = ST_BUMP;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_BUMP:    n_state = ST_OUT;
            ST_OUT:     if (i_res_ready) n_state = ST_IDLE;
            default:    n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_mem_req       = '0;
        o_s_axis_tready = 1'b0;
        o_res_valid     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr;
                o_mem_req.wdata = '{rank: '0, parent: r_clr};
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            ST_WALK_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = r_cur;
            end
            ST_WALK: begin
                o_mem_req.re    = !s_found;
                o_mem_req.raddr = w.parent;
            end
            ST_FIX_RD: begin
                o_mem_req.re    = (r_node != r_root);
                o_mem_req.raddr = r_node;
            end
            ST_FIX: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_node;
                o_mem_req.wdata = '{rank: w.rank, parent: r_root};
                o_mem_req.re    = !s_fix_end;
                o_mem_req.raddr = w.parent;
            end
            ST_FINISH: begin
            end
            ST_LINK: begin
                if (r_ra != r_root) begin
                    o_mem_req.we = 1'b1;
                    if (r_rank_a < r_rank) begin
                        o_mem_req.waddr = r_ra;
                        o_mem_req.wdata = '{rank: r_rank_a, parent: r_root};
                    end else begin
                        o_mem_req.waddr = r_root;
                        o_mem_req.wdata = '{rank: r_rank, parent: r_ra};
                    end
                end
            end
            ST_BUMP: begin
                o_mem_req.we    = (r_rank_a != RANK_MAX);
                o_mem_req.waddr = r_ra;
                o_mem_req.wdata = '{rank: r_rank_a + t_rank'(1), parent: r_ra};
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.we && o_mem_req.re) |-> (o_mem_req.waddr != o_mem_req.raddr))
        else $error("memory read and write hit the same entry in one cycle");

    a_fix_points_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX) |-> (o_mem_req.we && o_mem_req.wdata.parent == r_root))
        else $error("path compression wrote a parent other than the root");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_WALK_RD))
        else $error("accepted transaction did not start a walk");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(r_res)))
        else $error("pending result changed before it was taken");
`endif

endmodule
`default_nettype wire

### rtl/union_find_rank_compress.sv
// Channel   Dir  Signals              Contents
// s_axis    in   tdata[23:0], tuser   tdata: elem_a[9:0], elem_b[19:10]; tuser: cmd
// m_axis    out  tdata[15:0], tuser   tdata: root[9:0]; tuser: merged
//
// After reset the block sweeps the node memory and accepts nothing until the sweep ends.
// A find walks from elem_a to its root and compresses that path before the core
// accepts the next transaction.
// A union walks elem_a, then elem_b; an extra state raises the new root's rank on a tie.
// Each walk step is one read of the single node memory; compression adds a write per step.
// The output register frees the core while a result waits; a full register stalls it.
`default_nettype none
module union_find_rank_compress (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // elem_a, elem_b, zero pad
    input  wire logic [ufrc_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd
    input  wire logic                          i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // root, zero pad
    output logic [ufrc_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // merged
    output logic                               o_m_axis_tuser
);
    import ufrc_pkg::*;

    t_mem_req s_mem_req;
    t_node    s_mem_rdata;
    logic     s_res_valid;
    logic     s_res_ready;
    t_result  s_res;

    ufrc_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (s_mem_req),
        .o_rdata (s_mem_rdata)
    );

    ufrc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_mem_req       (s_mem_req),
        .i_mem_rdata     (s_mem_rdata),
        .o_res_valid     (s_res_valid),
        .o_res           (s_res),
        .i_res_ready     (s_res_ready)
    );

    ufrc_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res_valid     (s_res_valid),
        .i_res           (s_res),
        .o_res_ready     (s_res_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

### sim/union_find_rank_compress_tb.sv
`default_nettype none
module union_find_rank_compress_tb;
    import ufrc_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic   cmd;
        t_field elem_a;
        t_field elem_b;
        bit     wait_empty;
    } t_cmd_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // elem_a, elem_b, zero pad
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    // cmd
    logic                 i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // root, zero pad
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    // merged
    logic                 o_m_axis_tuser;

    t_idx      uf_parent [NUM_ELEMS];
    t_rank     uf_rank [NUM_ELEMS];
    t_cmd_item cmd_queue [$];
    t_result   root_queue [$];

    int mismatch_count = 0;
    int accepted_cmds = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int calm_left = 0;
    bit cmd_taken = 1'b0;
    bit no_idle = 1'b0;
    bit recv_hold = 1'b0;

    union_find_rank_compress dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_idx to_index(input t_field v);
        if (32'(v) >= NUM_ELEMS) begin
            return t_idx'(NUM_ELEMS - 1);
        end
        return t_idx'(v);
    endfunction

    function automatic t_idx find_and_compress(input t_idx start);
        t_idx node;
        t_idx top;
        t_idx up;
        int   steps;
        node = start;
        top = start;
        steps = 0;
        while (steps < NUM_ELEMS) begin
            up = to_index(t_field'(uf_parent[top]));
            if (up == top) begin
                break;
            end
            top = up;
            steps++;
        end
        steps = 0;
        while (node != top && steps < NUM_ELEMS) begin
            up = to_index(t_field'(uf_parent[node]));
            uf_parent[node] = top;
            node = up;
            steps++;
        end
        return top;
    endfunction

    function automatic t_result union_find_step(input logic cmd, input t_field fa,
                                                input t_field fb);
        t_idx    ra;
        t_idx    rb;
        t_result r;
        r.merged = 1'b0;
        if (cmd == CMD_FIND) begin
            r.root = t_field'(find_and_compress(to_index(fa)));
        end else begin
            ra = find_and_compress(to_index(fa));
            rb = find_and_compress(to_index(fb));
            if (ra == rb) begin
                r.root = t_field'(ra);
            end else if (uf_rank[ra] < uf_rank[rb]) begin
                uf_parent[ra] = rb;
                r.root = t_field'(rb);
                r.merged = 1'b1;
            end else begin
                uf_parent[rb] = ra;
                if (uf_rank[ra] == uf_rank[rb] && uf_rank[ra] != RANK_MAX) begin
                    uf_rank[ra] = uf_rank[ra] + 1'b1;
                end
                r.root = t_field'(ra);
                r.merged = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 60);
    endfunction

    task automatic push_cmd(input logic cmd, input int a, input int b, input bit wait_empty);
        t_cmd_item c;
        c.cmd = cmd;
        c.elem_a = t_field'(a);
        c.elem_b = t_field'(b);
        c.wait_empty = wait_empty;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic report_mismatch(input t_result exp_r, input bit have_exp);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (have_exp) begin
                $display("mismatch: expected root %0d merged %0d, got root %0d merged %0d",
                         exp_r.root, exp_r.merged, o_m_axis_tdata[FIELD_W-1:0],
                         o_m_axis_tuser);
            end else begin
                $display("mismatch: unexpected transaction root %0d merged %0d",
                         o_m_axis_tdata[FIELD_W-1:0], o_m_axis_tuser);
            end
        end
    endtask

    always @(posedge i_clk) begin : scoreboard_proc
        t_result exp_r;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            root_queue.insert(root_queue.size(),
                              union_find_step(i_s_axis_tuser,
                                              i_s_axis_tdata[FIELD_W-1:0],
                                              i_s_axis_tdata[2*FIELD_W-1:FIELD_W]));
            accepted_cmds <= accepted_cmds + 1;
            cmd_taken <= 1'b1;
            moved = 1'b1;
        end else begin
            cmd_taken <= 1'b0;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            moved = 1'b1;
            if (root_queue.size() == 0) begin
                report_mismatch(exp_r, 1'b0);
            end else begin
                exp_r = root_queue.pop_front();
                if (o_m_axis_tdata[FIELD_W-1:0] != exp_r.root
                        || o_m_axis_tuser != exp_r.merged) begin
                    report_mismatch(exp_r, 1'b1);
                end
            end
        end
        if (moved) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            no_idle <= ~no_idle;
            calm_left <= $urandom_range(100, 600);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    always @(negedge i_clk) begin : send_proc
        t_cmd_item c;
        if (i_rst_n && !(i_s_axis_tvalid && !cmd_taken)) begin
            if (send_gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (cmd_queue.size() != 0
                    && !(cmd_queue[0].wait_empty && root_queue.size() != 0)) begin
                c = cmd_queue.pop_front();
                i_s_axis_tdata <= S_TDATA_W'({c.elem_b, c.elem_a});
                i_s_axis_tuser <= c.cmd;
                i_s_axis_tvalid <= 1'b1;
                send_gap <= no_idle ? 0 : gap_len();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || recv_hold) begin
            i_m_axis_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            i_m_axis_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            recv_gap <= no_idle ? 0 : gap_len();
        end
    end

    // Long receiver stall while the sender keeps offering commands.
    initial begin
        wait (accepted_cmds >= 300);
        @(posedge i_clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        recv_hold <= 1'b0;
    end

    initial begin : main_proc
        int s;
        int i;
        int n;
        int k;
        int base;
        int span;
        int a;
        int b;
        for (i = 0; i < NUM_ELEMS; i++) begin
            uf_parent[i] = t_idx'(i);
            uf_rank[i] = '0;
        end

        push_cmd(CMD_FIND, 0, 1023, 1'b0);
        push_cmd(CMD_FIND, 1023, 0, 1'b0);
        push_cmd(CMD_UNION, 0, 1023, 1'b0);
        push_cmd(CMD_UNION, 1023, 0, 1'b0);
        push_cmd(CMD_FIND, 1023, 1023, 1'b0);
        push_cmd(CMD_UNION, 5, 5, 1'b0);
        push_cmd(CMD_UNION, 'h2AA, 'h155, 1'b0);
        push_cmd(CMD_FIND, 'h155, 'h2AA, 1'b0);
        push_cmd(CMD_UNION, 1, 2, 1'b0);
        push_cmd(CMD_UNION, 3, 1, 1'b0);
        for (s = 1; s < 8; s *= 2) begin
            for (i = 0; i < 8; i += 2 * s) begin
                push_cmd(CMD_UNION, 100 + i + s - 1, 100 + i + 2 * s - 1, 1'b0);
            end
        end
        push_cmd(CMD_FIND, 107, 0, 1'b0);
        push_cmd(CMD_FIND, 107, 0, 1'b0);
        push_cmd(CMD_FIND, 105, 0, 1'b0);
        push_cmd(CMD_UNION, 0, 100, 1'b0);
        push_cmd(CMD_FIND, 1023, 0, 1'b0);

        // Balanced merges over 256 elements drive the ranks up to eight.
        n = 0;
        for (s = 1; s < 256; s *= 2) begin
            for (i = 0; i < 256; i += 2 * s) begin
                a = 512 + i + $urandom_range(0, s - 1);
                b = 512 + i + s + $urandom_range(0, s - 1);
                if ($urandom_range(0, 1) == 1) begin
                    push_cmd(CMD_UNION, b, a, n == 0);
                end else begin
                    push_cmd(CMD_UNION, a, b, n == 0);
                end
                n++;
            end
        end
        for (i = 0; i < 40; i++) begin
            push_cmd(CMD_FIND, $urandom_range(512, 767), $urandom_range(0, 1023), 1'b0);
            n++;
        end

        while (n < 900) begin
            k = $urandom_range(0, 9);
            span = (k < 3) ? 8 : (k < 6) ? 32 : (k < 8) ? 128 : 1024;
            base = $urandom_range(0, 1024 - span);
            for (i = 0; i < 40; i++) begin
                a = base + $urandom_range(0, span - 1);
                b = ($urandom_range(0, 19) == 0) ? a : base + $urandom_range(0, span - 1);
                if ($urandom_range(0, 99) < 65) begin
                    push_cmd(CMD_UNION, a, b, n == 600);
                end else begin
                    push_cmd(CMD_FIND, a, $urandom_range(0, 1023), n == 600);
                end
                n++;
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || i_s_axis_tvalid || root_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(negedge i_clk);
        mismatch_count += root_queue.size();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
rtl/ufrc_pkg.sv
rtl/ufrc_mem.sv
rtl/ufrc_out.sv
rtl/ufrc_ctrl.sv
rtl/union_find_rank_compress.sv
sim/union_find_rank_compress_tb.sv
